// ===== sv/assert_macros.svh =====
// Assertion helper macros for the TLS SNI parser RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset
`define TLSSNI_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every clock edge outside reset
`define TLSSNI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tlssni_pkg.sv =====
// Shared types and constants of the TLS ClientHello SNI parser.
// No dependencies; used by the parser, the replay engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tlssni_pkg;

    // Verdict codes of a result word
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_MALF  = 2'd2;

    // APB register addresses
    localparam logic [1:0] ADDR_MAX_NAME_LEN = 2'd0;

    localparam logic [6:0] MAX_NAME_LEN_RST = 7'd15;

    // Verdict handed from the parser to the replay engine at record end
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] len;
    } t_verdict;

    // One result word
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] name_length;
        logic [7:0] name_byte;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/tlssni_ifs.sv =====
// Valid/ready channel interfaces of the TLS SNI parser (input bytes, result words).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tlssni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface tlssni_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] name_length;
    logic [7:0] name_byte;
    logic       last;
    modport source (output valid, output status, output name_length, output name_byte,
                    output last, input ready);
    modport sink (input valid, input status, input name_length, input name_byte,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/tlssni_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlssni_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tlssni_parser.sv =====
// Byte-serial ClientHello parser: walks the record, checks it and writes SNI bytes.
// Depends on tlssni_pkg; drives the write port of the name RAM.
`timescale 1ns / 1ps
`default_nettype none

module tlssni_parser #(
    parameter int NAME_CAP   = 64,
    parameter int RECORD_CAP = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [7:0]                  i_byte,
    input  wire logic [6:0]                  i_max_len,
    output tlssni_pkg::t_verdict             o_verdict,
    output logic                             o_we,
    output logic [$clog2(NAME_CAP)-1:0]      o_waddr,
    output logic [7:0]                       o_wdata
);

    localparam int AW = $clog2(NAME_CAP);
    localparam logic [16:0] REC_LIM = 17'(RECORD_CAP - 5);
    localparam logic [7:0]  CAP8    = 8'(NAME_CAP);
    localparam logic [15:0] CAP16   = 16'(NAME_CAP);

    typedef enum logic [14:0] {
        PH_HDR     = 15'b000000000000001,
        PH_HSHDR   = 15'b000000000000010,
        PH_VER     = 15'b000000000000100,
        PH_RAND    = 15'b000000000001000,
        PH_SIDLEN  = 15'b000000000010000,
        PH_SID     = 15'b000000000100000,
        PH_CLEN    = 15'b000000001000000,
        PH_CIPH    = 15'b000000010000000,
        PH_COMPLEN = 15'b000000100000000,
        PH_COMP    = 15'b000001000000000,
        PH_EXTSUM  = 15'b000010000000000,
        PH_EXTHDR  = 15'b000100000000000,
        PH_EXTBODY = 15'b001000000000000,
        PH_DONE    = 15'b010000000000000,
        PH_SKIP    = 15'b100000000000000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [15:0]        r_fc, n_fc;
    logic [31:0]        r_fv, n_fv;
    logic [15:0]        r_rec_len, n_rec_len;
    logic [15:0]        r_rec_left, n_rec_left;
    logic signed [18:0] r_bleft, n_bleft;
    logic [15:0]        r_ebl, n_ebl;
    logic [15:0]        r_kind, n_kind;
    logic [15:0]        r_elen, n_elen;
    logic               r_malf, n_malf;
    logic               r_fvalid, n_fvalid;
    logic [7:0]         r_flen, n_flen;
    logic [15:0]        r_slist, n_slist;
    logic [15:0]        r_sname, n_sname;
    logic               r_svalid, n_svalid;

    logic [15:0]        fc1;
    logic [31:0]        nfv;
    logic signed [18:0] bl2;
    logic [7:0]         lim;
    logic [15:0]        nm;
    logic [15:0]        kofs;
    logic               rec_end;
    logic               good;
    logic               has_name;

    // Next-state logic: one record byte per accepted word
    always_comb begin
        n_phase = r_phase;     n_fc = r_fc;         n_fv = r_fv;
        n_rec_len = r_rec_len; n_rec_left = r_rec_left;
        n_bleft = r_bleft;     n_ebl = r_ebl;       n_kind = r_kind;
        n_elen = r_elen;       n_malf = r_malf;     n_fvalid = r_fvalid;
        n_flen = r_flen;       n_slist = r_slist;   n_sname = r_sname;
        n_svalid = r_svalid;
        fc1 = r_fc + 16'd1;
        nfv = {r_fv[23:0], i_byte};
        bl2 = r_bleft;
        lim = ({1'b0, i_max_len} < CAP8) ? {1'b0, i_max_len} : CAP8;
        nm = {r_sname[15:8], i_byte};
        kofs = r_fc - 16'd5;
        rec_end = 1'b0;
        o_we = 1'b0;
        o_waddr = kofs[AW-1:0];
        o_wdata = i_byte;

        if (i_fire) begin
            if (r_phase == PH_HDR) begin
                // Record header: bytes 3 and 4 carry the length
                if (r_fc == 16'd3) n_rec_len = {i_byte, 8'h00};
                if (r_fc == 16'd4) n_rec_len = {r_rec_len[15:8], i_byte};
                n_fc = fc1;
                if (r_fc == 16'd4) begin
                    n_rec_left = n_rec_len;
                    n_malf = 1'b0;
                    n_fvalid = 1'b0;
                    n_flen = 8'd0;
                    n_fc = 16'd0;
                    n_fv = 32'd0;
                    if ({1'b0, n_rec_len} >= REC_LIM) begin
                        n_malf = 1'b1;
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_HSHDR;
                    end
                    rec_end = (n_rec_len == 16'd0);
                end
            end else begin
                case (r_phase)
                    PH_HSHDR: begin
                        n_fc = fc1;
                        if (fc1 == 16'd2 && i_byte != 8'd0) begin
                            n_malf = 1'b1; n_phase = PH_SKIP; n_fc = '0; n_fv = '0;
                        end else begin
                            if (fc1 >= 16'd3) n_fv = nfv;
                            if (fc1 == 16'd4) begin
                                if ({1'b0, nfv[15:0]} + 17'd4 != {1'b0, r_rec_len}) begin
                                    n_malf = 1'b1; n_phase = PH_SKIP; n_fc = '0; n_fv = '0;
                                end else begin
                                    n_bleft = $signed({3'b000, nfv[15:0]});
                                    n_phase = PH_VER; n_fc = '0; n_fv = '0;
                                end
                            end
                        end
                    end
                    PH_VER: begin
                        if (i_byte != 8'd3) begin
                            n_malf = 1'b1; n_phase = PH_SKIP; n_fc = '0; n_fv = '0;
                        end else begin
                            n_fc = fc1;
                            if (fc1 == 16'd2) begin
                                n_bleft = r_bleft - 19'sd34;
                                n_phase = PH_RAND; n_fc = '0; n_fv = '0;
                            end
                        end
                    end
                    PH_RAND: begin
                        n_fc = fc1;
                        if (fc1 == 16'd32) begin
                            n_phase = PH_SIDLEN; n_fc = '0; n_fv = '0;
                        end
                    end
                    PH_SIDLEN, PH_COMPLEN: begin
                        bl2 = r_bleft - 19'sd1 - $signed({11'd0, i_byte});
                        if (r_phase == PH_SIDLEN && i_byte > 8'd32) begin
                            n_malf = 1'b1; n_phase = PH_SKIP; n_fc = '0; n_fv = '0;
                        end else begin
                            n_bleft = bl2;
                            n_fc = '0; n_fv = '0;
                            if (bl2 <= 19'sd0) begin
                                n_malf = 1'b1; n_phase = PH_SKIP;
                            end else begin
                                n_ebl = {8'd0, i_byte};
                                if (r_phase == PH_SIDLEN)
                                    n_phase = (i_byte != 8'd0) ? PH_SID : PH_CLEN;
                                else
                                    n_phase = (i_byte != 8'd0) ? PH_COMP : PH_EXTSUM;
                            end
                        end
                    end
                    PH_SID, PH_CIPH, PH_COMP: begin
                        n_ebl = r_ebl - 16'd1;
                        if (n_ebl == 16'd0) begin
                            n_fc = '0; n_fv = '0;
                            if (r_phase == PH_SID) n_phase = PH_CLEN;
                            else if (r_phase == PH_CIPH) n_phase = PH_COMPLEN;
                            else n_phase = PH_EXTSUM;
                        end
                    end
                    PH_CLEN: begin
                        n_fv = nfv;
                        n_fc = fc1;
                        if (fc1 == 16'd2) begin
                            bl2 = r_bleft - 19'sd2 - $signed({3'b000, nfv[15:0]});
                            n_bleft = bl2;
                            n_fc = '0; n_fv = '0;
                            if (bl2 <= 19'sd0 || nfv[0] || nfv[15:0] == 16'd0) begin
                                n_malf = 1'b1; n_phase = PH_SKIP;
                            end else begin
                                n_ebl = nfv[15:0];
                                n_phase = PH_CIPH;
                            end
                        end
                    end
                    PH_EXTSUM: begin
                        n_fv = nfv;
                        n_fc = fc1;
                        if (fc1 == 16'd2) begin
                            bl2 = r_bleft - 19'sd2;
                            n_bleft = bl2;
                            n_fc = '0; n_fv = '0;
                            if (bl2 <= 19'sd0 || $signed({3'b000, nfv[15:0]}) != bl2) begin
                                n_malf = 1'b1; n_phase = PH_SKIP;
                            end else begin
                                n_phase = PH_EXTHDR;
                            end
                        end
                    end
                    PH_EXTHDR: begin
                        n_fv = nfv;
                        n_fc = fc1;
                        if (fc1 == 16'd4) begin
                            n_kind = nfv[31:16];
                            n_elen = nfv[15:0];
                            bl2 = r_bleft - 19'sd4 - $signed({3'b000, nfv[15:0]});
                            n_bleft = bl2;
                            n_fc = '0; n_fv = '0;
                            if (bl2 < 19'sd0) begin
                                n_malf = 1'b1; n_phase = PH_SKIP;
                            end else begin
                                n_svalid = 1'b0;
                                n_slist = '0;
                                n_sname = '0;
                                n_ebl = nfv[15:0];
                                n_phase = PH_EXTBODY;
                                // Empty extension finishes at once
                                if (nfv[15:0] == 16'd0) begin
                                    if (nfv[31:16] == 16'd0) begin
                                        n_fvalid = 1'b0;
                                        n_flen = 8'd0;
                                    end
                                    n_phase = (bl2 == 19'sd0) ? PH_DONE : PH_EXTHDR;
                                end
                            end
                        end
                    end
                    PH_EXTBODY: begin
                        // Server name list: list length, name type, name length, name
                        if (r_kind == 16'd0) begin
                            if (r_fc == 16'd0) n_slist = {i_byte, 8'h00};
                            else if (r_fc == 16'd1) n_slist = {r_slist[15:8], i_byte};
                            else if (r_fc == 16'd3) n_sname = {i_byte, 8'h00};
                            else if (r_fc == 16'd4) begin
                                n_sname = nm;
                                n_svalid = ({1'b0, r_slist} + 17'd2 == {1'b0, r_elen}) &&
                                           (r_slist > 16'd3) && (nm <= {8'd0, lim}) &&
                                           (nm <= r_slist - 16'd3);
                            end else if (r_fc >= 16'd5 && r_svalid && kofs < r_sname &&
                                         kofs < CAP16) begin
                                o_we = 1'b1;
                            end
                        end
                        n_fc = fc1;
                        n_ebl = r_ebl - 16'd1;
                        if (n_ebl == 16'd0) begin
                            if (r_kind == 16'd0) begin
                                n_fvalid = n_svalid;
                                n_flen = n_svalid ? n_sname[7:0] : 8'd0;
                            end
                            n_fc = '0; n_fv = '0;
                            n_phase = (r_bleft == 19'sd0) ? PH_DONE : PH_EXTHDR;
                        end
                    end
                    PH_DONE: begin
                        // Trailing bytes after a complete ClientHello
                        n_malf = 1'b1; n_phase = PH_SKIP; n_fc = '0; n_fv = '0;
                    end
                    default: begin
                    end
                endcase
                n_rec_left = (r_rec_left != 16'd0) ? r_rec_left - 16'd1 : r_rec_left;
                rec_end = (n_rec_left == 16'd0);
            end
        end

        // Verdict at record end, then back to the header
        good = !n_malf && (n_phase == PH_DONE);
        has_name = good && n_fvalid && (n_flen != 8'd0) && (n_flen <= CAP8);
        o_verdict.valid = rec_end;
        o_verdict.status = has_name ? tlssni_pkg::ST_FOUND :
                           (good ? tlssni_pkg::ST_NONE : tlssni_pkg::ST_MALF);
        o_verdict.len = has_name ? n_flen : 8'd0;
        if (rec_end) begin
            n_phase = PH_HDR;
            n_fc = '0;
            n_fv = '0;
            n_malf = 1'b0;
            n_fvalid = 1'b0;
            n_flen = 8'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;  r_fc <= '0;      r_fv <= '0;
            r_rec_len <= '0;    r_rec_left <= '0; r_bleft <= '0;
            r_ebl <= '0;        r_kind <= '0;    r_elen <= '0;
            r_malf <= 1'b0;     r_fvalid <= 1'b0; r_flen <= '0;
            r_slist <= '0;      r_sname <= '0;   r_svalid <= 1'b0;
        end else begin
            r_phase <= n_phase;     r_fc <= n_fc;         r_fv <= n_fv;
            r_rec_len <= n_rec_len; r_rec_left <= n_rec_left; r_bleft <= n_bleft;
            r_ebl <= n_ebl;         r_kind <= n_kind;     r_elen <= n_elen;
            r_malf <= n_malf;       r_fvalid <= n_fvalid; r_flen <= n_flen;
            r_slist <= n_slist;     r_sname <= n_sname;   r_svalid <= n_svalid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tlssni_replay.sv =====
// Result engine: reads the stored name from RAM and queues result words.
// Depends on tlssni_pkg and assert_macros.svh; drives the read port of the name RAM.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlssni_replay #(
    parameter int NAME_CAP = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  tlssni_pkg::t_verdict             i_verdict,
    output logic                             o_busy,
    output logic                             o_re,
    output logic [$clog2(NAME_CAP)-1:0]      o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output tlssni_pkg::t_result               o_res
);

    localparam int AW = $clog2(NAME_CAP);

    logic                 r_busy;
    logic [1:0]           r_status;
    logic [7:0]           r_len;
    logic [7:0]           r_idx;
    logic                 r_rd_v;
    tlssni_pkg::t_result  r_rd_meta;
    tlssni_pkg::t_result  r_q [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;

    logic                 pop;
    logic                 issue;
    logic                 issue_last;
    logic                 found;
    logic [2:0]           occ;
    tlssni_pkg::t_result  push_word;

    // Issue one RAM read (or status word) per cycle while the queue has room
    always_comb begin
        found = (r_status == tlssni_pkg::ST_FOUND);
        pop = (r_cnt != 2'd0) && i_ready;
        occ = {1'b0, r_cnt} + {2'b00, r_rd_v} - {2'b00, pop};
        issue = r_busy && (occ < 3'd2);
        issue_last = !found || (r_idx + 8'd1 == r_len);
        o_re = issue && found;
        o_raddr = r_idx[AW-1:0];
        push_word = r_rd_meta;
        push_word.name_byte = (r_rd_meta.status == tlssni_pkg::ST_FOUND) ? i_rdata : 8'd0;
    end

    // Replay sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_verdict.valid) begin
                r_busy <= 1'b1;
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 8'd1;
                if (issue_last) r_busy <= 1'b0;
            end
            r_rd_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_verdict.valid) begin
            r_status <= i_verdict.status;
            r_len <= i_verdict.len;
        end
        if (issue) begin
            r_rd_meta.status <= r_status;
            r_rd_meta.name_length <= r_len[6:0];
            r_rd_meta.name_byte <= 8'd0;
            r_rd_meta.last <= issue_last;
        end
        if (r_rd_v) begin
            r_q[r_wp] <= push_word;
        end
    end

    // Two-word output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (r_rd_v) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, r_rd_v} - {1'b0, pop};
        end
    end

    assign o_busy = r_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_res = r_q[r_rp];

    `TLSSNI_ASSERT(a_q_no_overflow, i_clk, i_rst_n, r_rd_v, (r_cnt != 2'd2) || pop, "queue overflow")
    `TLSSNI_ASSERT(a_q_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count out of range")
    `TLSSNI_ASSERT(a_verdict_idle, i_clk, i_rst_n, i_verdict.valid, !r_busy, "verdict while replaying")
    `TLSSNI_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, issue && issue_last && !i_verdict.valid, !r_busy, "replay did not end")

endmodule

`default_nettype wire

// ===== sv/tls_client_hello_sni_parser_unit.sv =====
// Top level of the TLS ClientHello SNI parser: channels, APB register, name RAM.
// Depends on tlssni_pkg, tlssni_ifs, tlssni_ram, tlssni_parser and tlssni_replay.
`timescale 1ns / 1ps
`default_nettype none

// Takes one TLS record byte per cycle (header first) and at record end emits a
// verdict: one word per server-name byte with status 0, or a single status word
// (1 = well formed without a usable name, 2 = malformed); the final word has last
// set. Parsing runs at one byte per cycle with no stalls. After the last record
// byte, input holds off while the result is replayed: one read of the name RAM
// per byte of a found name (one per cycle while the two-word output queue has
// room) or a single status word, and longer while that queue is full because
// the sink stalls. The first result word becomes valid once the replay has
// started, its read or status word has been issued and it has entered the queue.
// A stalled sink does not lose data. max_name_len (APB address 0, reset 15)
// bounds the accepted name. The name RAM needs no clearing after reset.
module tls_client_hello_sni_parser_unit #(
    parameter int NAME_CAP   = 64,
    parameter int RECORD_CAP = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tlssni_in_if.sink        i_in,
    tlssni_out_if.source     o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(NAME_CAP);

    logic [6:0]            r_max_len;
    logic                  in_fire;
    logic                  busy;
    tlssni_pkg::t_verdict  verdict;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [AW-1:0]         raddr;
    logic [7:0]            rdata;
    tlssni_pkg::t_result   res;

    // APB register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= tlssni_pkg::MAX_NAME_LEN_RST;
        end else if (psel && penable && pwrite && paddr == tlssni_pkg::ADDR_MAX_NAME_LEN) begin
            r_max_len <= pwdata[6:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == tlssni_pkg::ADDR_MAX_NAME_LEN) ? {25'd0, r_max_len} : 32'd0;

    // Input handshake
    assign i_in.ready = !busy;
    assign in_fire = i_in.valid && !busy;

    tlssni_parser #(
        .NAME_CAP   (NAME_CAP),
        .RECORD_CAP (RECORD_CAP)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_fire),
        .i_byte    (i_in.in_byte),
        .i_max_len (r_max_len),
        .o_verdict (verdict),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    tlssni_ram #(
        .WIDTH (8),
        .DEPTH (NAME_CAP)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tlssni_replay #(
        .NAME_CAP (NAME_CAP)
    ) u_replay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_verdict (verdict),
        .o_busy    (busy),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_res     (res)
    );

    // Output payload
    assign o_out.status = res.status;
    assign o_out.name_length = res.name_length;
    assign o_out.name_byte = res.name_byte;
    assign o_out.last = res.last;

endmodule

`default_nettype wire
